FILE: hdl/apdr_pkg.sv
package apdr_pkg;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int CODE_W    = 12;
  localparam int GAIN_W    = 24;
  localparam int ERR_W     = 13;
  localparam int DERR_W    = 14;
  localparam int ISUM_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // largest value the 12-bit code field holds
  localparam int CODE_FIELD_MAX = 4095;

  // register reset values
  localparam logic [SAMPLE_W-1:0]      SETPOINT_RST = 12'd330;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST   = 24'sd3277;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST   = 24'sd524;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST   = 24'sd0;

  // integral limits
  localparam logic signed [ISUM_W-1:0] ISUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ISUM_W-1:0] ISUM_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 2'd0,
    REG_GAIN_P   = 2'd1,
    REG_GAIN_I   = 2'd2,
    REG_GAIN_D   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      setpoint;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } pid_cfg_t;

  // one word leaving the averager: done marks the end of a block
  typedef struct packed {
    logic                valid;
    logic                done;
    logic                enable;
    logic [SAMPLE_W-1:0] average;
  } avg_word_t;

endpackage

FILE: hdl/apdr_if.sv
interface apdr_in_if;
  import apdr_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                enable;

  modport source (output valid, output sample, output enable, input ready);
  modport sink   (input valid, input sample, input enable, output ready);
endinterface

interface apdr_out_if;
  import apdr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   dac_code;
  logic [SAMPLE_W-1:0] average;

  modport source (output valid, output dac_code, output average, input ready);
  modport sink   (input valid, input dac_code, input average, output ready);
endinterface

FILE: hdl/apdr_pid.sv
module apdr_pid #(
  parameter int DAC_LIM = 4095
) (
  input  logic                clk,
  input  logic                rst_n,
  input  apdr_pkg::pid_cfg_t  cfg,
  input  apdr_pkg::avg_word_t avg_in,
  output logic                avg_ready,
  apdr_out_if.source          out_chan
);
  import apdr_pkg::*;

  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + ISUM_W;
  localparam int D_W    = GAIN_W + DERR_W;
  localparam int ACC_W  = I_W + 2;
  localparam int FRAC_W = 16;
  localparam int HI_W   = ACC_W - FRAC_W;
  localparam logic [HI_W-1:0] LIM_WIDE = HI_W'(DAC_LIM);

  // PID memory
  logic signed [ISUM_W-1:0] err_total_r;
  logic signed [ERR_W-1:0]  prior_err_r;

  // error stage
  logic                     s3_valid_r;
  logic                     s3_en_r;
  logic [SAMPLE_W-1:0]      s3_avg_r;
  logic signed [ERR_W-1:0]  s3_e_r;
  logic signed [ISUM_W-1:0] s3_sum_r;
  logic signed [DERR_W-1:0] s3_de_r;

  // product stage
  logic                     s4_valid_r;
  logic                     s4_en_r;
  logic [SAMPLE_W-1:0]      s4_avg_r;
  logic signed [P_W-1:0]    s4_p_r;
  logic signed [I_W-1:0]    s4_i_r;
  logic signed [D_W-1:0]    s4_d_r;

  // result register
  logic                     out_valid_r;
  logic [CODE_W-1:0]        out_code_r;
  logic [SAMPLE_W-1:0]      out_avg_r;

  logic out_rdy, s4_rdy, s3_rdy, take;

  assign out_rdy   = !out_valid_r || out_chan.ready;
  assign s4_rdy    = !s4_valid_r || out_rdy;
  assign s3_rdy    = !s3_valid_r || s4_rdy;
  assign avg_ready = s3_rdy;
  assign take      = avg_in.valid && s3_rdy;

  // error, saturated integral and derivative
  logic signed [ERR_W-1:0]  e;
  logic signed [ISUM_W:0]   sum_wide;
  logic signed [ISUM_W-1:0] sum_sat;
  logic signed [DERR_W-1:0] de;

  always_comb begin
    e        = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, avg_in.average});
    sum_wide = (ISUM_W+1)'(err_total_r) + (ISUM_W+1)'(e);
    if (sum_wide[ISUM_W] != sum_wide[ISUM_W-1]) begin
      sum_sat = sum_wide[ISUM_W] ? ISUM_MIN : ISUM_MAX;
    end else begin
      sum_sat = sum_wide[ISUM_W-1:0];
    end
    de = DERR_W'(e) - DERR_W'(prior_err_r);
  end

  // PID memory runs in word order: a disabled word clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_total_r <= '0;
      prior_err_r <= '0;
    end else if (take) begin
      if (!avg_in.enable) begin
        err_total_r <= '0;
        prior_err_r <= '0;
      end else if (avg_in.done) begin
        err_total_r <= sum_sat;
        prior_err_r <= e;
      end
    end
  end

  // error stage: only block ends go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_r <= avg_in.valid && avg_in.done;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_en_r  <= avg_in.enable;
      s3_avg_r <= avg_in.average;
      s3_e_r   <= e;
      s3_sum_r <= sum_sat;
      s3_de_r  <= de;
    end
  end

  // product stage: three gain multiplies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_en_r  <= s3_en_r;
      s4_avg_r <= s3_avg_r;
      s4_p_r   <= P_W'(cfg.gain_p) * P_W'(s3_e_r);
      s4_i_r   <= I_W'(cfg.gain_i) * I_W'(s3_sum_r);
      s4_d_r   <= D_W'(cfg.gain_d) * D_W'(s3_de_r);
    end
  end

  // sum, drop fraction, clamp to the DAC range
  logic signed [ACC_W-1:0] acc;
  logic [HI_W-1:0]         acc_hi;
  logic [CODE_W-1:0]       code_nxt;

  always_comb begin
    acc    = ACC_W'(s4_p_r) + ACC_W'(s4_i_r) + ACC_W'(s4_d_r);
    acc_hi = acc[ACC_W-1:FRAC_W];
    if (!s4_en_r || acc[ACC_W-1]) begin
      code_nxt = '0;
    end else if (acc_hi > LIM_WIDE) begin
      code_nxt = CODE_W'(DAC_LIM);
    end else begin
      code_nxt = acc_hi[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_code_r <= code_nxt;
      out_avg_r  <= s4_avg_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.dac_code = out_code_r;
  assign out_chan.average  = out_avg_r;

endmodule

FILE: hdl/averaged_pid_dac_regulator.sv
// Averaged PID regulator for a 12-bit DAC.
// Input channel in_chan carries one ADC sample and the drive enable per word.
// Every AVG_LEN accepted words close a block; the block's truncated mean is
// compared with the setpoint and one positional PID step produces a DAC code,
// clamped to 0..min(DAC_MAX, 4095). One result word (dac_code, average) leaves
// on out_chan per block; the other words give no result. A word with enable
// low clears the integral and last error; a block that ends disabled reports
// code 0 with its average.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 setpoint,
// 1..3 gains P, I, D in signed Q8.16); write only while the block is idle.
// Throughput: one word per cycle while out_chan does not stall. The result
// of a block passes these steps (accumulate, divide by reciprocal multiply,
// error and integral update, gain multiplies, sum and clamp), one register
// each.
// Reset (rst_n low, synchronous) empties the pipeline, restarts the block
// count, clears the PID memory and loads the default registers.
// When out_chan stalls, words keep entering until the stages behind the held
// result are full; then in_chan.ready drops.
module averaged_pid_dac_regulator #(
  parameter int AVG_LEN = 8,
  parameter int DAC_MAX = 4095
) (
  input  logic                               clk,
  input  logic                               rst_n,
  apdr_in_if.sink                            in_chan,
  apdr_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [apdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apdr_pkg::CFG_W-1:0]         cfg_data
);
  import apdr_pkg::*;

  localparam int CNT_W   = $clog2(AVG_LEN);
  localparam int TOTAL_W = SAMPLE_W + CNT_W;
  localparam int SHIFT   = TOTAL_W + CNT_W;
  localparam int RECIP_W = SHIFT;
  localparam int PROD_W  = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + AVG_LEN - 1) / AVG_LEN);
  localparam logic [CNT_W-1:0]   LAST  = CNT_W'(AVG_LEN - 1);
  localparam int DAC_LIM = (DAC_MAX > CODE_FIELD_MAX) ? CODE_FIELD_MAX : DAC_MAX;

  // configuration registers
  pid_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= SETPOINT_RST;
      cfg_r.gain_p   <= GAIN_P_RST;
      cfg_r.gain_i   <= GAIN_I_RST;
      cfg_r.gain_d   <= GAIN_D_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT: cfg_r.setpoint <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_P:   cfg_r.gain_p   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:   cfg_r.gain_i   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:   cfg_r.gain_d   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  logic pid_ready, s2_rdy, s1_rdy, in_acc;
  logic s1_valid_r, s2_valid_r;

  assign s2_rdy        = !s2_valid_r || pid_ready;
  assign s1_rdy        = !s1_valid_r || s2_rdy;
  assign in_chan.ready = s1_rdy;
  assign in_acc        = in_chan.valid && s1_rdy;

  // block accumulator
  logic [TOTAL_W-1:0] sum_r;
  logic [TOTAL_W-1:0] sum_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               s1_done_r;
  logic               s1_en_r;
  logic [TOTAL_W-1:0] s1_total_r;

  assign sum_nxt = sum_r + TOTAL_W'(in_chan.sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_r <= in_acc;
      end
      if (in_acc) begin
        if (cnt_r == LAST) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_done_r  <= (cnt_r == LAST);
      s1_en_r    <= in_chan.enable;
      s1_total_r <= sum_nxt;
    end
  end

  // mean by reciprocal multiply, exact over the whole sum range
  logic [PROD_W-1:0]   quot_prod;
  logic                s2_done_r;
  logic                s2_en_r;
  logic [SAMPLE_W-1:0] s2_avg_r;

  assign quot_prod = PROD_W'(s1_total_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_done_r <= s1_done_r;
      s2_en_r   <= s1_en_r;
      s2_avg_r  <= quot_prod[SHIFT +: SAMPLE_W];
    end
  end

  avg_word_t avg_word;

  assign avg_word.valid   = s2_valid_r;
  assign avg_word.done    = s2_done_r;
  assign avg_word.enable  = s2_en_r;
  assign avg_word.average = s2_avg_r;

  apdr_pid #(
    .DAC_LIM (DAC_LIM)
  ) u_pid (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .avg_in    (avg_word),
    .avg_ready (pid_ready),
    .out_chan  (out_chan)
  );

endmodule
